// ===== rtl/fee_rate_ranked_table_unit_defines.svh =====
// ---------------------------------------------------------------------------
// fee rate ranked table assertion macros
// shared property forms for the table unit checks
// ---------------------------------------------------------------------------
`ifndef FEE_RATE_RANKED_TABLE_UNIT_DEFINES_SVH
`define FEE_RATE_RANKED_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, reset aware
`define FRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset aware
`define FRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/frt_pkg.sv =====
// ---------------------------------------------------------------------------
// fee rate ranked table package
// request and result words, entry layout and codes
// ---------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int FEE_W    = 51;
	localparam int WEIGHT_W = 22;
	localparam int HANDLE_W = 32;
	localparam int KEY_W    = 256;
	localparam int FILL_W   = 7;

	localparam logic [1:0] REQ_STORE  = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_EVICTED   = 3'd1;
	localparam logic [2:0] ST_DROPPED   = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_REMOVED   = 3'd5;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [63:0]         key_word0;
		logic [63:0]         key_word1;
		logic [63:0]         key_word2;
		logic [63:0]         key_word3;
		logic [FEE_W-1:0]    fee_amount;
		logic [WEIGHT_W-1:0] item_weight;
		logic [HANDLE_W-1:0] item_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [HANDLE_W-1:0] found_handle;
		logic [FILL_W-1:0]   fill_level;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [FEE_W-1:0]    fee;
		logic [WEIGHT_W-1:0] weight;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/frt_rank_cmp.sv =====
// ---------------------------------------------------------------------------
// fee rate rank comparator
// registered cross products, then exact compare of fee_a/w_a against fee_b/w_b
// ---------------------------------------------------------------------------
`default_nettype none

module frt_rank_cmp (
	input  wire                          clk,
	input  wire  [frt_pkg::FEE_W-1:0]    fee_a,
	input  wire  [frt_pkg::WEIGHT_W-1:0] w_a,
	input  wire  [frt_pkg::FEE_W-1:0]    fee_b,
	input  wire  [frt_pkg::WEIGHT_W-1:0] w_b,
	output logic                         above
);
	import frt_pkg::*;

	localparam int HI_W = FEE_W - 32;
	localparam int PW   = FEE_W + WEIGHT_W;

	// partial products, split at bit 32
	logic [32+WEIGHT_W-1:0]   a_lo_s1, b_lo_s1;
	logic [HI_W+WEIGHT_W-1:0] a_hi_s1, b_hi_s1;
	logic [PW-1:0]            prod_a, prod_b;

	always_ff @(posedge clk) begin
		a_lo_s1 <= fee_a[31:0] * w_b;
		a_hi_s1 <= fee_a[FEE_W-1:32] * w_b;
		b_lo_s1 <= fee_b[31:0] * w_a;
		b_hi_s1 <= fee_b[FEE_W-1:32] * w_a;
	end

	assign prod_a = {a_hi_s1, 32'd0} + PW'(a_lo_s1);
	assign prod_b = {b_hi_s1, 32'd0} + PW'(b_lo_s1);
	assign above  = prod_a > prod_b;

endmodule

`default_nettype wire

// ===== rtl/fee_rate_ranked_table_unit.sv =====
// ---------------------------------------------------------------------------
// fee rate ranked table unit
// bounded table kept in descending fee per weight order, with store,
// lookup by key and removal by key, walked through one entry memory
// ---------------------------------------------------------------------------
// channel   | ports                  | handshake
// ----------+------------------------+-------------------------------------
// request   | start, busy, request   | word taken when start high, busy low
// result    | result_valid, result   | one-cycle strobe, cannot be held off
//
// walk: a request walks the single entry memory, with one read, one
//   product stage and one compare per entry walked
// reset: arst_n clears the fill count and the sequencer; entry memory holds
//   no reset, only entries below the fill count are ever used
// stalls: busy stays high from the accepting edge until the result strobe;
//   the result leaves in the cycle busy falls, the receiver cannot stall
// ---------------------------------------------------------------------------
`default_nettype none

module fee_rate_ranked_table_unit #(
	parameter int CAPACITY = frt_pkg::CAPACITY_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	output logic           busy,
	input  frt_pkg::req_t  request,
	output logic           result_valid,
	output frt_pkg::rsp_t  result
);
	import frt_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_CMP, S_FIN} state_t;

	state_t        state_q;
	req_t          req_q;
	entry_t        held_q;       // entry being carried down the table on store
	logic          inserted_q;
	logic [CW-1:0] idx_q;        // walk position
	logic [CW-1:0] keep_q;       // compaction write position on remove
	logic [CW-1:0] count_q;      // fill count
	logic          hit_q;
	logic [HANDLE_W-1:0] handle_q;

	// entry memory, one write and one registered read port
	entry_t        mem [CAPACITY];
	entry_t        rdata_q;
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;

	logic          above;
	logic          key_hit;
	logic [CW-1:0] cnt_next;
	logic [2:0]    status_next;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[idx_q[IW-1:0]];
	end

	frt_rank_cmp u_rank (
		.clk   (clk),
		.fee_a (rdata_q.fee),
		.w_a   (rdata_q.weight),
		.fee_b (req_q.fee_amount),
		.w_b   (req_q.item_weight),
		.above (above)
	);

	assign key_hit = rdata_q.key ==
		{req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};

	// write port steering
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = held_q;
		if (state_q == S_CMP) begin
			if (req_q.req_type == REQ_STORE) begin
				// new entry lands before the first entry not strictly above it
				we = inserted_q || !above;
			end else if (req_q.req_type == REQ_REMOVE) begin
				we    = !key_hit;
				waddr = keep_q[IW-1:0];
				wdata = rdata_q;
			end
		end else if (state_q == S_FIN) begin
			// carried entry goes to the tail while there is room
			if (req_q.req_type == REQ_STORE && count_q != CW'(CAPACITY)) begin
				we    = 1'b1;
				waddr = count_q[IW-1:0];
			end
		end
	end

	// end of request: new count and status
	always_comb begin
		cnt_next    = count_q;
		status_next = ST_NOT_FOUND;
		case (req_q.req_type)
			REQ_STORE: begin
				if (count_q != CW'(CAPACITY)) begin
					cnt_next    = count_q + CW'(1);
					status_next = ST_STORED;
				end else if (inserted_q) begin
					status_next = ST_EVICTED;
				end else begin
					status_next = ST_DROPPED;
				end
			end
			REQ_LOOKUP: status_next = hit_q ? ST_FOUND : ST_NOT_FOUND;
			REQ_REMOVE: begin
				cnt_next    = keep_q;
				status_next = hit_q ? ST_REMOVED : ST_NOT_FOUND;
			end
			default: status_next = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			result_valid <= 1'b0;
			result       <= '0;
			req_q        <= '0;
			held_q       <= '0;
			handle_q     <= '0;
			inserted_q   <= 1'b0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			keep_q       <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q        <= request;
						held_q.key   <= {request.key_word3, request.key_word2,
							request.key_word1, request.key_word0};
						held_q.fee    <= request.fee_amount;
						held_q.weight <= request.item_weight;
						held_q.handle <= request.item_handle;
						inserted_q   <= 1'b0;
						hit_q        <= 1'b0;
						handle_q     <= '0;
						idx_q        <= '0;
						keep_q       <= '0;
						// unused request code walks nothing
						state_q <= (request.req_type == REQ_STORE ||
							request.req_type == REQ_LOOKUP ||
							request.req_type == REQ_REMOVE) ? S_RD : S_FIN;
					end
				end
				S_RD: begin
					// read of idx_q issued in this cycle
					state_q <= (idx_q == count_q) ? S_FIN : S_MUL;
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_RD;
					case (req_q.req_type)
						REQ_STORE: begin
							if (inserted_q || !above) begin
								held_q     <= rdata_q;
								inserted_q <= 1'b1;
							end
						end
						REQ_LOOKUP: begin
							if (key_hit) begin
								hit_q    <= 1'b1;
								handle_q <= rdata_q.handle;
								state_q  <= S_FIN;
							end
						end
						REQ_REMOVE: begin
							if (key_hit) begin
								hit_q <= 1'b1;
							end else begin
								keep_q <= keep_q + CW'(1);
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					count_q             <= cnt_next;
					result.status       <= status_next;
					result.found_handle <= (status_next == ST_FOUND) ? handle_q : '0;
					result.fill_level   <= FILL_W'(cnt_next);
					result_valid        <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// checks
	`include "fee_rate_ranked_table_unit_defines.svh"

	`FRT_ASSERT_NOW(a_result_idle, result_valid, !busy, "result strobe while busy")
	`FRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`FRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count above capacity")
	`FRT_ASSERT_NEXT(a_one_strobe, result_valid, !result_valid, "result strobe held two cycles")

endmodule

`default_nettype wire

// ===== test/fee_rate_ranked_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fee rate ranked table unit testbench
// drives store, lookup, remove and unused words against a behavioural copy
// of the ranked table and checks every result word field by field
// ---------------------------------------------------------------------------
`default_nettype none

module fee_rate_ranked_table_unit_tb;

	import frt_pkg::*;

	localparam int CAP       = 64;
	localparam int N_RANDOM  = 2000;
	localparam int CYCLE_CAP = 1500000;

	// clock and reset
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic result_valid;
	req_t request;
	rsp_t result;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	fee_rate_ranked_table_unit #(.CAPACITY(CAP)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	// behavioural copy of the table
	entry_t tbl_entry [CAP];
	int     tbl_fill;

	// pending request words and expected result words
	req_t   pending_words [$];
	bit     pause_marks [$];
	rsp_t   expected_rsp [$];
	int     error_count;
	bit     stimulus_done;
	int     cycle_count;

	// keys seen so far, reused so lookups and removals hit
	logic [255:0] key_pool [$];

	// a strictly above b when fee_a * w_b > fee_b * w_a, exact 73-bit products
	function automatic bit rate_above(logic [50:0] fa, logic [21:0] wa,
			logic [50:0] fb, logic [21:0] wb);
		logic [72:0] pa;
		logic [72:0] pb;
		pa = 73'(fa) * 73'(wb);
		pb = 73'(fb) * 73'(wa);
		return pa > pb;
	endfunction

	// apply one request word to the table copy and return its result
	function automatic rsp_t table_apply(req_t rq);
		rsp_t         r;
		logic [255:0] k;
		int           pos;
		int           keep;
		bit           ins;
		k = {rq.key_word3, rq.key_word2, rq.key_word1, rq.key_word0};
		r.status = ST_NOT_FOUND;
		r.found_handle = '0;
		case (rq.req_type)
			REQ_STORE: begin
				pos = 0;
				ins = 1'b1;
				while (pos < tbl_fill && rate_above(tbl_entry[pos].fee,
						tbl_entry[pos].weight, rq.fee_amount, rq.item_weight))
					pos++;
				if (tbl_fill == CAP) begin
					if (pos == tbl_fill) begin
						ins = 1'b0;
						r.status = ST_DROPPED;
					end else begin
						tbl_fill--;
						r.status = ST_EVICTED;
					end
				end else begin
					r.status = ST_STORED;
				end
				if (ins) begin
					for (int i = tbl_fill; i > pos; i--)
						tbl_entry[i] = tbl_entry[i-1];
					tbl_entry[pos] = '{key: k, fee: rq.fee_amount,
						weight: rq.item_weight, handle: rq.item_handle};
					tbl_fill++;
				end
			end
			REQ_LOOKUP: begin
				for (int i = 0; i < tbl_fill; i++) begin
					if (tbl_entry[i].key == k) begin
						r.status = ST_FOUND;
						r.found_handle = tbl_entry[i].handle;
						break;
					end
				end
			end
			REQ_REMOVE: begin
				keep = 0;
				for (int i = 0; i < tbl_fill; i++) begin
					if (tbl_entry[i].key != k) begin
						tbl_entry[keep] = tbl_entry[i];
						keep++;
					end
				end
				if (keep != tbl_fill)
					r.status = ST_REMOVED;
				tbl_fill = keep;
			end
			default: ;
		endcase
		r.found_handle = r.found_handle;
		r.fill_level = 7'(tbl_fill);
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random word; store keys go to the pool, lookups and removals mostly reuse pool keys
	function automatic req_t make_word(logic [1:0] kind);
		req_t         rq;
		logic [255:0] k;
		int           sel;
		sel = $urandom_range(0, 9);
		if (key_pool.size() > 0 && sel < 7)
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (sel == 7)
			k = '0;
		else if (sel == 8)
			k = '1;
		else
			k = {rand64(), rand64(), rand64(), rand64()};
		if (kind == REQ_STORE && sel < 3)
			k = {rand64(), rand64(), rand64(), rand64()};
		rq.req_type = kind;
		{rq.key_word3, rq.key_word2, rq.key_word1, rq.key_word0} = k;
		case ($urandom_range(0, 5))
			0: rq.fee_amount = '1;
			1: rq.fee_amount = 51'($urandom_range(0, 20));
			default: rq.fee_amount = 51'(rand64());
		endcase
		case ($urandom_range(0, 5))
			0: rq.item_weight = '1;
			1: rq.item_weight = 22'($urandom_range(1, 8));
			default: rq.item_weight = 22'($urandom_range(1, 22'h3FFFFF));
		endcase
		rq.item_handle = $urandom();
		if (kind == REQ_STORE) begin
			key_pool.push_back(k);
			if (key_pool.size() > 96)
				void'(key_pool.pop_front());
		end
		return rq;
	endfunction

	task automatic queue_word(req_t rq, bit pause_first);
		pending_words.push_back(rq);
		pause_marks.push_back(pause_first);
	endtask

	// stimulus plan
	initial begin
		req_t rq;
		int   pick;
		tbl_fill = 0;
		stimulus_done = 1'b0;

		// directed: extremes, equal rates, duplicates, unused type
		rq = '0;
		rq.req_type = REQ_LOOKUP;
		queue_word(rq, 1'b0);
		rq.req_type = REQ_REMOVE;
		queue_word(rq, 1'b0);
		rq.req_type = REQ_STORE;
		rq.fee_amount = '1;
		rq.item_weight = 22'd1;
		rq.item_handle = '1;
		queue_word(rq, 1'b0);
		rq.item_handle = 32'h1;
		queue_word(rq, 1'b0);
		rq.key_word0 = '1; rq.key_word1 = '1; rq.key_word2 = '1; rq.key_word3 = '1;
		rq.fee_amount = '0;
		rq.item_weight = '1;
		rq.item_handle = 32'h2;
		queue_word(rq, 1'b0);
		rq.fee_amount = 51'd2;
		rq.item_weight = 22'd4;
		rq.item_handle = 32'h3;
		queue_word(rq, 1'b0);
		rq.fee_amount = 51'd1;
		rq.item_weight = 22'd2;
		rq.item_handle = 32'h4;
		queue_word(rq, 1'b0);
		rq.req_type = REQ_LOOKUP;
		queue_word(rq, 1'b0);
		rq.req_type = 2'd3;
		queue_word(rq, 1'b0);
		rq = '0;
		rq.req_type = REQ_LOOKUP;
		queue_word(rq, 1'b0);
		rq.req_type = REQ_REMOVE;
		queue_word(rq, 1'b1);
		rq.key_word0 = '1; rq.key_word1 = '1; rq.key_word2 = '1; rq.key_word3 = '1;
		queue_word(rq, 1'b0);
		rq.req_type = REQ_LOOKUP;
		queue_word(rq, 1'b0);

		// fill past capacity: random rates evict, zero rates drop
		for (int i = 0; i < CAP + 6; i++) begin
			rq = make_word(REQ_STORE);
			if (i >= CAP && i[0]) begin
				rq.fee_amount = '0;
				rq.item_weight = '1;
			end
			queue_word(rq, 1'b0);
		end

		// random mix, mostly stores and lookups over known keys
		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				rq = make_word(REQ_STORE);
			else if (pick < 75)
				rq = make_word(REQ_LOOKUP);
			else if (pick < 97)
				rq = make_word(REQ_REMOVE);
			else
				rq = make_word(2'd3);
			queue_word(rq, (n % 500) == 250);
		end
		stimulus_done = 1'b1;
	end

	// driver
	int   gap_left;
	bit   word_loaded;
	bit   waiting_drain;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			gap_left <= 0;
			word_loaded <= 1'b0;
			waiting_drain <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_rsp.push_back(table_apply(request));
				start <= 1'b0;
				word_loaded <= 1'b0;
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			end else if (!start) begin
				if (!word_loaded && pending_words.size() > 0) begin
					request <= pending_words.pop_front();
					waiting_drain <= pause_marks.pop_front();
					word_loaded <= 1'b1;
				end else if (word_loaded) begin
					// hold off until the table has answered everything
					if (waiting_drain && (expected_rsp.size() > 0 || busy)) begin
					end else if (gap_left > 0) begin
						gap_left <= gap_left - 1;
					end else begin
						waiting_drain <= 1'b0;
						start <= 1'b1;
					end
				end
			end
		end
	end

	// monitor
	rsp_t want;

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, result);
				error_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					error_count++;
				end
				if (result.found_handle !== want.found_handle) begin
					$display("%0t: handle expected %h actual %h",
						$time, want.found_handle, result.found_handle);
					error_count++;
				end
				if (result.fill_level !== want.fill_level) begin
					$display("%0t: fill expected %0d actual %0d",
						$time, want.fill_level, result.fill_level);
					error_count++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("fee_rate_ranked_table_unit_tb: errors");
			$finish;
		end
	end

	// reset, then wait for the stimulus to drain
	initial begin
		error_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!stimulus_done || pending_words.size() > 0 || word_loaded || start ||
				expected_rsp.size() > 0)
			@(posedge clk);
		repeat (3 * CAP + 20) @(posedge clk);
		if (error_count == 0 && expected_rsp.size() == 0)
			$display("fee_rate_ranked_table_unit_tb: clean");
		else
			$display("fee_rate_ranked_table_unit_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_rank_cmp.sv
rtl/fee_rate_ranked_table_unit.sv
test/fee_rate_ranked_table_unit_tb.sv
